/* rtl/frequency_weighted_age_replacement_macros.svh */
// Assertion macros for the page replacement table.
`ifndef FREQUENCY_WEIGHTED_AGE_REPLACEMENT_MACROS_SVH
`define FREQUENCY_WEIGHTED_AGE_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
`define FWAR_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define FWAR_ASSERT_NXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define FWAR_ASSERT_IMP(label, clk, rst, a, c, msg)
`define FWAR_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

/* rtl/fwar_pkg.sv */
// Shared types and constants for the page replacement table.
package fwar_pkg;
   localparam int PAGE_WIDTH = 31;
   localparam int SLOT_WIDTH = 4;
   localparam int TIME_WIDTH = 32;

   typedef struct packed {
      logic [PAGE_WIDTH-1:0] page_id;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_WIDTH-1:0] slot;
      logic                  evicted;
      logic [PAGE_WIDTH-1:0] evicted_page_id;
   } rsp_type;
endpackage

/* rtl/fwar_if.sv */
// Valid/ready channel interfaces for requests and responses.
interface fwar_req_if import fwar_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fwar_rsp_if import fwar_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/frequency_weighted_age_replacement.sv */
// Top level: LRFU-style page table with memory-held entries and serial scan.
//
// Usage: one page access request per req transaction (page_id); one rsp
// transaction per request with hit, slot, evicted and evicted_page_id.
// The entry table (page, last-use, count) lives in one synchronous memory
// with a registered read port; valid bits are flip-flops cleared at reset.
// Every request first sweeps all CAPACITY entries, one memory read per
// cycle, to look for a hit and the lowest free slot. A full-table miss
// makes a second sweep that stages each candidate in a register and
// compares it against the current best one per cycle. The entry is then
// written back.
// The response is registered in S_WR after the lookup sweep on a hit or a
// free-slot miss, and after the second sweep and S_CMP on an eviction.
// A new request is taken only in S_IDLE, once the previous one has gone
// through S_WR and S_OUT; the block handles one request at a time.
// The response sits in an output register; while the receiver stalls, the
// block holds it and takes no new request until it drains.
// Reset (synchronous, active high) clears valid bits, the access clock and
// the control state; no clearing pass is needed.
`include "frequency_weighted_age_replacement_macros.svh"
module frequency_weighted_age_replacement import fwar_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   fwar_req_if.sink   req,
   fwar_rsp_if.source rsp
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int EW = PAGE_WIDTH + TIME_WIDTH + COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [EW-1:0]         mem [CAPACITY];
   logic [EW-1:0]         rd_ff;
   logic [CAPACITY-1:0]   valid_ff;
   logic [TIME_WIDTH-1:0] clock_ff;
   logic [PAGE_WIDTH-1:0] pid_ff;
   logic [IW:0]           addr_ff;     // read address counter
   logic [IW:0]           idx_ff;      // index of data in rd_ff
   logic                  rdv_ff;
   logic                  hit_ff, free_ff;
   logic [IW-1:0]         tgt_ff;
   logic [EW-1:0]         tgt_data_ff;
   logic [IW-1:0]         best_ff, cidx_ff;
   logic [TIME_WIDTH-1:0] best_age_ff, cage_ff;
   logic [COUNT_WIDTH:0]  best_den_ff, cden_ff;
   logic [PAGE_WIDTH-1:0] best_page_ff, cpage_ff;
   logic                  cmpv_ff, first_ff;
   logic                  better;
   rsp_type               rsp_ff;
   logic                  rspv_ff;

   logic [PAGE_WIDTH-1:0]  rd_page;
   logic [TIME_WIDTH-1:0]  rd_time, rd_age;
   logic [COUNT_WIDTH-1:0] rd_cnt;
   assign rd_page = rd_ff[EW-1 -: PAGE_WIDTH];
   assign rd_time = rd_ff[COUNT_WIDTH +: TIME_WIDTH];
   assign rd_cnt  = rd_ff[COUNT_WIDTH-1:0];
   assign rd_age  = clock_ff - rd_time;

   fwar_score #(.COUNT_WIDTH(COUNT_WIDTH)) u_score (
      .cand_age (cage_ff),
      .cand_den (cden_ff),
      .best_age (best_age_ff),
      .best_den (best_den_ff),
      .better   (better)
   );

   assign req.ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp.valid = rspv_ff;
   assign rsp.data  = rsp_ff;

   logic [IW-1:0]  ra;
   logic           rd_en, scanning;
   assign scanning = (state_ff == S_LOOK) || (state_ff == S_SCAN);
   assign rd_en = scanning && (addr_ff < (IW+1)'(CAPACITY));
   assign ra    = addr_ff[IW-1:0];

   // synchronous table memory read
   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= mem[ra];
   end

   // write back the target entry
   always_ff @(posedge clock) begin
      if (state_ff == S_WR) mem[tgt_ff] <= tgt_data_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req.valid && req.ready) state_in = S_LOOK;
         S_LOOK: if (rdv_ff && idx_ff == (IW+1)'(CAPACITY-1)) begin
            if (hit_ff || free_ff) state_in = S_WR;
            else if (valid_ff[idx_ff[IW-1:0]] && rd_page == pid_ff) state_in = S_WR;
            else if (!valid_ff[idx_ff[IW-1:0]]) state_in = S_WR;
            else state_in = S_SCAN;
         end
         S_SCAN: if (rdv_ff && idx_ff == (IW+1)'(CAPACITY-1)) state_in = S_CMP;
         S_CMP:  state_in = S_WR;
         S_WR:   state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         clock_ff <= '0;
         rspv_ff  <= 1'b0;
         rdv_ff   <= 1'b0;
         cmpv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rspv_ff <= 1'b0;
         rdv_ff <= rd_en;
         idx_ff <= addr_ff;
         if (rd_en) addr_ff <= addr_ff + 1'b1;
         // stage candidate ahead of the score compare
         cmpv_ff <= (state_ff == S_SCAN) && rdv_ff;
         cidx_ff <= idx_ff[IW-1:0];
         cage_ff <= rd_age;
         cden_ff <= {1'b0, rd_cnt} + 1'b1;
         cpage_ff <= rd_page;
         case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               pid_ff   <= req.data.page_id;
               clock_ff <= clock_ff + 1'b1;
               addr_ff  <= '0;
               hit_ff   <= 1'b0;
               free_ff  <= 1'b0;
            end
            S_LOOK: if (rdv_ff && !hit_ff) begin
               if (valid_ff[idx_ff[IW-1:0]] && rd_page == pid_ff) begin
                  hit_ff <= 1'b1;
                  tgt_ff <= idx_ff[IW-1:0];
                  tgt_data_ff <= {pid_ff, clock_ff,
                     (rd_cnt < CMAX) ? rd_cnt + 1'b1 : rd_cnt};
               end else if (!valid_ff[idx_ff[IW-1:0]] && !free_ff) begin
                  free_ff <= 1'b1;
                  tgt_ff  <= idx_ff[IW-1:0];
               end
               if (idx_ff == (IW+1)'(CAPACITY-1)) begin
                  addr_ff  <= '0;
                  first_ff <= 1'b1;
               end
            end
            S_SCAN: begin
               if (rdv_ff && first_ff) begin
                  first_ff     <= 1'b0;
                  best_ff      <= '0;
                  best_age_ff  <= rd_age;
                  best_den_ff  <= {1'b0, rd_cnt} + 1'b1;
                  best_page_ff <= rd_page;
               end else if (cmpv_ff && better) begin
                  best_ff <= cidx_ff; best_age_ff <= cage_ff;
                  best_den_ff <= cden_ff; best_page_ff <= cpage_ff;
               end
            end
            S_CMP: begin
               // compare the last staged candidate here
               if (cmpv_ff && better) begin
                  best_ff <= cidx_ff; best_page_ff <= cpage_ff;
                  tgt_ff <= cidx_ff;
               end else tgt_ff <= best_ff;
            end
            S_WR: begin
               valid_ff[tgt_ff] <= 1'b1;
               rspv_ff <= 1'b1;
               rsp_ff.hit  <= hit_ff;
               rsp_ff.slot <= SLOT_WIDTH'(tgt_ff);
               rsp_ff.evicted <= !hit_ff && !free_ff;
               rsp_ff.evicted_page_id <= (!hit_ff && !free_ff) ? best_page_ff : '0;
            end
            default: ;
         endcase
         if (state_ff == S_LOOK && state_in == S_WR && !hit_ff
             && !(valid_ff[idx_ff[IW-1:0]] && rd_page == pid_ff))
            tgt_data_ff <= {pid_ff, clock_ff, COUNT_WIDTH'(1)};
         if (state_ff == S_CMP) tgt_data_ff <= {pid_ff, clock_ff, COUNT_WIDTH'(1)};
      end
   end

   `FWAR_ASSERT_IMP(a_hold_busy, clock, reset, rspv_ff, !req.ready, "input open while busy")
   `FWAR_ASSERT_NXT(a_wr_out, clock, reset, state_ff == S_WR, rspv_ff, "no response after write")
   `FWAR_ASSERT_IMP(a_evict_full, clock, reset, state_ff == S_CMP, &valid_ff, "evict with free slot")
endmodule

/* rtl/fwar_score.sv */
// Cross-multiply score compare of the staged candidate against the current best.
module fwar_score import fwar_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic [TIME_WIDTH-1:0]  cand_age,
   input  logic [COUNT_WIDTH:0]   cand_den,
   input  logic [TIME_WIDTH-1:0]  best_age,
   input  logic [COUNT_WIDTH:0]   best_den,
   output logic                   better
);
   localparam int PW = TIME_WIDTH + COUNT_WIDTH + 1;
   logic [PW-1:0] lhs, rhs;

   // cross-multiply both scores, then compare; ties keep the best
   assign lhs    = PW'(cand_age) * PW'(best_den);
   assign rhs    = PW'(best_age) * PW'(cand_den);
   assign better = lhs > rhs;
endmodule

/* bench/tb_frequency_weighted_age_replacement.sv */
// Self-checking testbench for the frequency-weighted age page replacement table.
`timescale 1ns / 100ps
module tb_frequency_weighted_age_replacement;
   import fwar_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fwar_req_if req_if ();
   fwar_rsp_if rsp_if ();

   frequency_weighted_age_replacement #(
      .CAPACITY(CAPACITY),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   always #5 clock = ~clock;

   // Predicted table contents
   logic                   tbl_valid [CAPACITY];
   logic [PAGE_WIDTH-1:0]  tbl_page  [CAPACITY];
   logic [TIME_WIDTH-1:0]  tbl_used  [CAPACITY];
   logic [COUNT_WIDTH-1:0] tbl_count [CAPACITY];
   logic [TIME_WIDTH-1:0]  access_time;

   rsp_type pending_rsp [$];
   int      mismatches = 0;
   int      rsp_count = 0;
   int      hit_count = 0;
   int      evict_count = 0;
   int      cycle_count = 0;
   int      rx_wait = 0;
   int      rx_draw = 0;
   bit      hold_off = 1'b0;

   // Compute the response for one access and update the predicted table
   function automatic rsp_type predict_access(logic [PAGE_WIDTH-1:0] pid);
      rsp_type r;
      int target;
      int best;
      logic [63:0] age_i, age_b, den_i, den_b;
      r = '0;
      target = -1;
      access_time = access_time + 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (tbl_valid[i] && tbl_page[i] == pid) begin
            if (tbl_count[i] != COUNT_MAX) tbl_count[i] = tbl_count[i] + 1'b1;
            tbl_used[i] = access_time;
            r.hit = 1'b1;
            r.slot = i[SLOT_WIDTH-1:0];
            return r;
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (!tbl_valid[i] && target < 0) target = i;
      end
      if (target < 0) begin
         best = 0;
         age_b = {32'd0, access_time - tbl_used[0]};
         den_b = 64'(tbl_count[0]) + 64'd1;
         for (int i = 1; i < CAPACITY; i++) begin
            age_i = {32'd0, access_time - tbl_used[i]};
            den_i = 64'(tbl_count[i]) + 64'd1;
            if (age_i * den_b > age_b * den_i) begin
               best = i;
               age_b = age_i;
               den_b = den_i;
            end
         end
         target = best;
         r.evicted = 1'b1;
         r.evicted_page_id = tbl_page[target];
      end
      tbl_valid[target] = 1'b1;
      tbl_page[target] = pid;
      tbl_count[target] = COUNT_WIDTH'(1);
      tbl_used[target] = access_time;
      r.slot = target[SLOT_WIDTH-1:0];
      return r;
   endfunction

   // Directed rows: page id, and a typed expectation where it is obvious
   typedef struct {
      logic [PAGE_WIDTH-1:0] page_id;
      bit                    typed;
      rsp_type               rsp;
   } access_row_type;

   access_row_type directed_rows [$];

   // Offer one transaction after a random idle gap, hold it until accepted
   task automatic send_access(logic [PAGE_WIDTH-1:0] pid);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data.page_id <= pid;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic issue(logic [PAGE_WIDTH-1:0] pid, bit typed, rsp_type typed_rsp);
      rsp_type p;
      p = predict_access(pid);
      if (typed && p !== typed_rsp) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row disagrees with predictor: page %h typed %p predicted %p",
                     pid, typed_rsp, p);
      end
      pending_rsp.push_back(p);
      send_access(pid);
   endtask

   // Receiver: random wait per transaction, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_wait <= $urandom_range(0, 3);
      end else if (rsp_if.valid && rsp_if.ready) begin
         rx_draw = $urandom_range(0, 3);
         rx_wait <= rx_draw;
         rsp_if.ready <= (rx_draw == 0) && !hold_off;
      end else if (rx_wait != 0) begin
         rx_wait <= rx_wait - 1;
         rsp_if.ready <= (rx_wait == 1) && !hold_off;
      end else begin
         rsp_if.ready <= !hold_off;
      end
   end

   // Check each response transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_if.data);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (e.hit) hit_count++;
            if (e.evicted) evict_count++;
            if (rsp_if.data.hit !== e.hit || rsp_if.data.slot !== e.slot ||
                rsp_if.data.evicted !== e.evicted ||
                rsp_if.data.evicted_page_id !== e.evicted_page_id) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %p actual %p", e, rsp_if.data);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_frequency_weighted_age_replacement NOT OK");
         $finish;
      end
   end

   // Long receiver hold-off while the sender keeps offering
   initial begin
      @(negedge reset);
      repeat (400) @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic void add_row(logic [PAGE_WIDTH-1:0] pid, bit typed = 1'b0,
                                   rsp_type r = '0);
      access_row_type a;
      a.page_id = pid;
      a.typed = typed;
      a.rsp = r;
      directed_rows.push_back(a);
   endfunction

   // Main sequencing: reset, directed rows, then random traffic
   initial begin : main_sequence
      logic [PAGE_WIDTH-1:0] working_set [24];
      logic [PAGE_WIDTH-1:0] pid;
      rsp_type r;
      int pick;
      int sent;
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_page[i] = '0;
         tbl_used[i] = '0;
         tbl_count[i] = '0;
      end
      access_time = '0;
      sent = 0;

      // After reset: fill slots in order, extremes of the id first
      r = '0; r.slot = SLOT_WIDTH'(0); add_row('0, 1'b1, r);
      r = '0; r.slot = SLOT_WIDTH'(1); add_row('1, 1'b1, r);
      r = '0; r.hit = 1'b1; r.slot = SLOT_WIDTH'(1); add_row('1, 1'b1, r);
      r = '0; r.hit = 1'b1; r.slot = SLOT_WIDTH'(0); add_row('0, 1'b1, r);
      for (int i = 2; i < CAPACITY; i++) add_row(PAGE_WIDTH'(32'h5555_0000 + i));
      // Full table: misses evict, and a hit raises a count
      add_row(31'h2AAA_AAAA);
      add_row(31'h1234_5678);
      add_row(31'h5555_0003);
      add_row(31'h5555_0003);
      add_row(31'h0000_0001);
      add_row(31'h4000_0000);
      add_row(31'h5555_0005);

      // Working set larger than the table, so hits and evictions mix
      for (int k = 0; k < 24; k++) working_set[k] = PAGE_WIDTH'($urandom());
      working_set[0] = '0;
      working_set[1] = '1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         issue(directed_rows[k].page_id, directed_rows[k].typed, directed_rows[k].rsp);
         sent++;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            pid = PAGE_WIDTH'($urandom());
         end else if (pick == 1) begin
            working_set[$urandom_range(0, 23)] = PAGE_WIDTH'($urandom());
            pid = working_set[$urandom_range(0, 23)];
         end else begin
            pid = working_set[$urandom_range(0, 23)];
         end
         issue(pid, 1'b0, '0);
         sent++;
      end
      req_if.valid <= 1'b0;

      // Drain outstanding responses
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);

      $display("Ran %0d accesses: %0d hits, %0d evictions, random waits on both sides",
               sent, hit_count, evict_count);
      $display("and one long receiver hold-off that filled the block and stalled requests.");
      if (mismatches == 0 && rsp_count == sent)
         $display("tb_frequency_weighted_age_replacement OK");
      else
         $display("tb_frequency_weighted_age_replacement NOT OK");
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl
rtl/fwar_pkg.sv
rtl/fwar_if.sv
rtl/fwar_score.sv
rtl/frequency_weighted_age_replacement.sv
bench/tb_frequency_weighted_age_replacement.sv
